### src/pou_pkg.sv
`default_nettype none
package pou_pkg;

  localparam int POS_W           = 32;
  localparam int HDG_W           = 16;
  localparam int STEP_W          = 20;
  localparam int GUARD_W         = 10;
  localparam int DP_W            = 32;
  localparam int MID_W           = 17;
  localparam int PROD_W          = 64;
  localparam int GAIN_SHIFT      = 40;
  localparam int DELTA_W         = PROD_W - GAIN_SHIFT;
  localparam int ATAN_DEPTH      = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  localparam logic signed [DP_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

  localparam logic [31:0] ATAN_TURN32 [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HDG_W-1:0]  heading;
    logic signed [STEP_W-1:0] step_forward;
    logic signed [HDG_W-1:0]  step_turn;
    logic signed [STEP_W-1:0] step_slip;
  } pou_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [HDG_W-1:0] new_heading;
    logic                    saturated;
  } pou_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HDG_W-1:0] new_heading;
  } pou_side_t;

  // arctangent of 2^-i in turns, rounded half up to abits bits
  function automatic logic [31:0] atan_step(input int idx, input int abits);
    logic [32:0] tmp;
    tmp = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - abits));
    return 32'(tmp >> (32 - abits));
  endfunction

endpackage
`default_nettype wire

### src/pose_odometry_update_core.sv
`default_nettype none
// Planar odometry pose update. Each beat carries a pose and a motion step; the
// step vector (forward, slip) is rotated by the mid-step heading through a
// CORDIC_STAGES-stage pipelined CORDIC, scaled by the inverse CORDIC gain and
// added to the position with saturation. One beat is accepted per cycle while
// in_stall is low; each beat then passes through registered steps in order:
// angle prep and quadrant fold, one register per CORDIC stage, gain multiply,
// rounding, and add/clamp. Every stage holds its own valid bit; out_stall
// back-pressures only through stages that are occupied, so bubbles are
// filled before in_stall rises.
module pose_odometry_update_core #(
  parameter int CORDIC_STAGES = pou_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = pou_pkg::ANGLE_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  pou_pkg::pou_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output pou_pkg::pou_out_t  out_data
);
  import pou_pkg::*;

  logic                       p_valid, p_stall;
  logic signed [DP_W-1:0]     p_x, p_y;
  logic signed [ANGLE_BITS:0] p_a;
  pou_side_t                  p_side;
  logic                       c_valid, c_stall;
  logic signed [DP_W-1:0]     c_x, c_y;
  pou_side_t                  c_side;

  pou_prep #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(p_valid),
    .out_stall(p_stall),
    .out_x    (p_x),
    .out_y    (p_y),
    .out_a    (p_a),
    .out_side (p_side)
  );

  pou_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (p_valid),
    .in_stall (p_stall),
    .in_x     (p_x),
    .in_y     (p_y),
    .in_a     (p_a),
    .in_side  (p_side),
    .out_valid(c_valid),
    .out_stall(c_stall),
    .out_x    (c_x),
    .out_y    (c_y),
    .out_side (c_side)
  );

  pou_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c_valid),
    .in_stall (c_stall),
    .in_x     (c_x),
    .in_y     (c_y),
    .in_side  (c_side),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // input only backs up when a result is waiting and every stage is full
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.new_x == {1'b0, {(POS_W-1){1'b1}}} ||
       out_data.new_x == {1'b1, {(POS_W-1){1'b0}}} ||
       out_data.new_y == {1'b0, {(POS_W-1){1'b1}}} ||
       out_data.new_y == {1'b1, {(POS_W-1){1'b0}}}))
    else $error("saturated flag without a clamped coordinate");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

### src/pou_prep.sv
`default_nettype none
module pou_prep #(
  parameter int ANGLE_BITS = pou_pkg::ANGLE_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  pou_pkg::pou_in_t              in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [pou_pkg::DP_W-1:0] out_x,
  output logic signed [pou_pkg::DP_W-1:0] out_y,
  output logic signed [ANGLE_BITS:0]    out_a,
  output pou_pkg::pou_side_t            out_side
);
  import pou_pkg::*;

  localparam logic signed [ANGLE_BITS:0] Quarter = (ANGLE_BITS+1)'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [ANGLE_BITS:0] Half    = (ANGLE_BITS+1)'(1) <<< (ANGLE_BITS - 1);

  logic [MID_W-1:0]              mid;
  logic signed [ANGLE_BITS-1:0]  ang;
  logic signed [ANGLE_BITS:0]    ang_ext;
  logic signed [ANGLE_BITS:0]    a_nxt;
  logic signed [DP_W-1:0]        x0, y0, x_nxt, y_nxt;
  pou_side_t                     side_nxt;
  logic                          valid_r;
  logic signed [DP_W-1:0]        x_r, y_r;
  logic signed [ANGLE_BITS:0]    a_r;
  pou_side_t                     side_r;

  assign mid = {in_data.heading, 1'b0} + {in_data.step_turn[HDG_W-1], in_data.step_turn};

  generate
    if (ANGLE_BITS >= MID_W) begin : g_up
      logic [MID_W+ATAN_DEPTH-1:0] wide;
      assign wide = {mid, {ATAN_DEPTH{1'b0}}};
      assign ang  = wide[MID_W+ATAN_DEPTH-1 -: ANGLE_BITS];
    end else begin : g_dn
      logic [MID_W-1:0] rnd;
      assign rnd = mid + (MID_W'(1) << (MID_W - 1 - ANGLE_BITS));
      assign ang = rnd[MID_W-1 -: ANGLE_BITS];
    end
  endgenerate

  assign ang_ext = {ang[ANGLE_BITS-1], ang};
  assign x0 = {{(DP_W-STEP_W-GUARD_W){in_data.step_forward[STEP_W-1]}},
               in_data.step_forward, {GUARD_W{1'b0}}};
  assign y0 = {{(DP_W-STEP_W-GUARD_W){in_data.step_slip[STEP_W-1]}},
               in_data.step_slip, {GUARD_W{1'b0}}};

  // fold into the right half plane
  always_comb begin
    x_nxt = x0;
    y_nxt = y0;
    a_nxt = ang_ext;
    priority if (ang_ext > Quarter) begin
      x_nxt = -x0;
      y_nxt = -y0;
      a_nxt = ang_ext - Half;
    end else if (ang_ext < -Quarter) begin
      x_nxt = -x0;
      y_nxt = -y0;
      a_nxt = ang_ext + Half;
    end
  end

  assign side_nxt.pos_x       = in_data.pos_x;
  assign side_nxt.pos_y       = in_data.pos_y;
  assign side_nxt.new_heading = in_data.heading + in_data.step_turn;

  assign in_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_a     = a_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

### src/pou_cordic.sv
`default_nettype none
module pou_cordic #(
  parameter int CORDIC_STAGES = pou_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = pou_pkg::ANGLE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [pou_pkg::DP_W-1:0]  in_x,
  input  wire signed [pou_pkg::DP_W-1:0]  in_y,
  input  wire signed [ANGLE_BITS:0]       in_a,
  input  pou_pkg::pou_side_t              in_side,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [pou_pkg::DP_W-1:0] out_x,
  output logic signed [pou_pkg::DP_W-1:0] out_y,
  output pou_pkg::pou_side_t              out_side
);
  import pou_pkg::*;

  logic                       v_r    [CORDIC_STAGES];
  logic signed [DP_W-1:0]     x_r    [CORDIC_STAGES];
  logic signed [DP_W-1:0]     y_r    [CORDIC_STAGES];
  logic signed [ANGLE_BITS:0] a_r    [CORDIC_STAGES];
  pou_side_t                  side_r [CORDIC_STAGES];
  logic [CORDIC_STAGES:0]     st;

  assign st[CORDIC_STAGES] = out_stall;

  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [ANGLE_BITS:0] Step = (ANGLE_BITS+1)'(atan_step(i, ANGLE_BITS));
      logic                       vi;
      logic signed [DP_W-1:0]     xi, yi;
      logic signed [ANGLE_BITS:0] ai;
      pou_side_t                  si;

      if (i == 0) begin : g_first
        assign vi = in_valid;
        assign xi = in_x;
        assign yi = in_y;
        assign ai = in_a;
        assign si = in_side;
      end else begin : g_next
        assign vi = v_r[i-1];
        assign xi = x_r[i-1];
        assign yi = y_r[i-1];
        assign ai = a_r[i-1];
        assign si = side_r[i-1];
      end

      assign st[i] = v_r[i] && st[i+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (!st[i]) begin
          v_r[i] <= vi;
        end
      end

      always_ff @(posedge clk) begin
        if (!st[i]) begin
          side_r[i] <= si;
          if (!ai[ANGLE_BITS]) begin
            x_r[i] <= xi - (yi >>> i);
            y_r[i] <= yi + (xi >>> i);
            a_r[i] <= ai - Step;
          end else begin
            x_r[i] <= xi + (yi >>> i);
            y_r[i] <= yi - (xi >>> i);
            a_r[i] <= ai + Step;
          end
        end
      end
    end
  endgenerate

  assign in_stall  = st[0];
  assign out_valid = v_r[CORDIC_STAGES-1];
  assign out_x     = x_r[CORDIC_STAGES-1];
  assign out_y     = y_r[CORDIC_STAGES-1];
  assign out_side  = side_r[CORDIC_STAGES-1];

endmodule
`default_nettype wire

### src/pou_scale.sv
`default_nettype none
module pou_scale (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [pou_pkg::DP_W-1:0] in_x,
  input  wire signed [pou_pkg::DP_W-1:0] in_y,
  input  pou_pkg::pou_side_t             in_side,
  output logic                           out_valid,
  input  wire                            out_stall,
  output pou_pkg::pou_out_t              out_data
);
  import pou_pkg::*;

  localparam logic signed [PROD_W-1:0] RoundHalf = PROD_W'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [POS_W-1:0]  PosMax = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  PosMin = {1'b1, {(POS_W-1){1'b0}}};

  // gain multiply
  logic                     vm_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  pou_side_t                sm_r;
  // rounding
  logic                      vr_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  pou_side_t                 sr_r;
  logic signed [PROD_W-1:0]  rx, ry;
  // add and clamp
  logic                      vo_r;
  pou_out_t                  out_r;
  logic signed [POS_W:0]     sx, sy;
  logic                      ovx, ovy;
  pou_out_t                  out_nxt;
  logic                      st_m, st_r, st_o;

  assign st_o     = vo_r && out_stall;
  assign st_r     = vr_r && st_o;
  assign st_m     = vm_r && st_r;
  assign in_stall = st_m;

  assign rx = px_r + RoundHalf;
  assign ry = py_r + RoundHalf;

  assign sx  = {sr_r.pos_x[POS_W-1], sr_r.pos_x} +
               {{(POS_W+1-DELTA_W){dx_r[DELTA_W-1]}}, dx_r};
  assign sy  = {sr_r.pos_y[POS_W-1], sr_r.pos_y} +
               {{(POS_W+1-DELTA_W){dy_r[DELTA_W-1]}}, dy_r};
  assign ovx = sx[POS_W] ^ sx[POS_W-1];
  assign ovy = sy[POS_W] ^ sy[POS_W-1];

  always_comb begin
    out_nxt.new_x       = ovx ? (sx[POS_W] ? PosMin : PosMax) : sx[POS_W-1:0];
    out_nxt.new_y       = ovy ? (sy[POS_W] ? PosMin : PosMax) : sy[POS_W-1:0];
    out_nxt.new_heading = sr_r.new_heading;
    out_nxt.saturated   = ovx || ovy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vr_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (!st_m) begin
        vm_r <= in_valid;
      end
      if (!st_r) begin
        vr_r <= vm_r;
      end
      if (!st_o) begin
        vo_r <= vr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!st_m) begin
      px_r <= in_x * INV_GAIN_Q30;
      py_r <= in_y * INV_GAIN_Q30;
      sm_r <= in_side;
    end
    if (!st_r) begin
      dx_r <= rx[PROD_W-1:GAIN_SHIFT];
      dy_r <= ry[PROD_W-1:GAIN_SHIFT];
      sr_r <= sm_r;
    end
    if (!st_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps

class pose_scoreboard #(int STAGES = 16, int ABITS = 16);
  pou_pkg::pou_out_t expected_poses[$];
  int unsigned n_poses;
  int unsigned n_results;
  int unsigned n_clamped;
  int unsigned n_bad;

  function new();
    n_poses = 0;
    n_results = 0;
    n_clamped = 0;
    n_bad = 0;
  endfunction

  // mid-step rotation of (forward, slip), then saturating add to the pose
  function pou_pkg::pou_out_t predict_pose(pou_pkg::pou_in_t it);
    longint px, py, th, fw, tn, sl;
    longint mid_raw, a, x, y, xs, ys, qtr, hlf, nx, ny, hsum;
    logic signed [pou_pkg::MID_W-1:0] m17;
    logic [63:0] step_u;
    int i;
    pou_pkg::pou_out_t r;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    th = longint'(it.heading);
    fw = longint'(it.step_forward);
    tn = longint'(it.step_turn);
    sl = longint'(it.step_slip);
    mid_raw = 2 * th + tn;
    m17 = mid_raw[pou_pkg::MID_W-1:0];
    a = longint'(m17);
    if (ABITS >= pou_pkg::MID_W) begin
      a = a <<< (ABITS - pou_pkg::MID_W);
    end else begin
      a = (a + (longint'(1) <<< (pou_pkg::MID_W - 1 - ABITS))) >>> (pou_pkg::MID_W - ABITS);
    end
    a = (a <<< (64 - ABITS)) >>> (64 - ABITS);
    x = fw <<< pou_pkg::GUARD_W;
    y = sl <<< pou_pkg::GUARD_W;
    qtr = longint'(1) <<< (ABITS - 2);
    hlf = longint'(1) <<< (ABITS - 1);
    if (a > qtr) begin
      x = -x;
      y = -y;
      a = a - hlf;
    end else if (a < -qtr) begin
      x = -x;
      y = -y;
      a = a + hlf;
    end
    for (i = 0; i < STAGES && i < pou_pkg::ATAN_DEPTH; i++) begin
      step_u = (64'(pou_pkg::ATAN_TURN32[i]) + (64'd1 << (31 - ABITS))) >> (32 - ABITS);
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x = x - ys;
        y = y + xs;
        a = a - longint'(step_u);
      end else begin
        x = x + ys;
        y = y - xs;
        a = a + longint'(step_u);
      end
    end
    x = (x * longint'(pou_pkg::INV_GAIN_Q30) + (longint'(1) <<< (pou_pkg::GAIN_SHIFT - 1)))
        >>> pou_pkg::GAIN_SHIFT;
    y = (y * longint'(pou_pkg::INV_GAIN_Q30) + (longint'(1) <<< (pou_pkg::GAIN_SHIFT - 1)))
        >>> pou_pkg::GAIN_SHIFT;
    nx = px + x;
    ny = py + y;
    r.saturated = 1'b0;
    if (nx > 64'sh7FFFFFFF) begin
      nx = 64'sh7FFFFFFF;
      r.saturated = 1'b1;
    end else if (nx < -64'sh80000000) begin
      nx = -64'sh80000000;
      r.saturated = 1'b1;
    end
    if (ny > 64'sh7FFFFFFF) begin
      ny = 64'sh7FFFFFFF;
      r.saturated = 1'b1;
    end else if (ny < -64'sh80000000) begin
      ny = -64'sh80000000;
      r.saturated = 1'b1;
    end
    hsum = th + tn;
    r.new_x = nx[31:0];
    r.new_y = ny[31:0];
    r.new_heading = hsum[15:0];
    return r;
  endfunction

  function void note_pose(pou_pkg::pou_in_t it);
    pou_pkg::pou_out_t e;
    e = predict_pose(it);
    expected_poses.push_back(e);
    n_poses++;
    if (e.saturated) n_clamped++;
  endfunction

  function void check_pose(pou_pkg::pou_out_t got);
    pou_pkg::pou_out_t e;
    if (expected_poses.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("unexpected pose result: x=%0d y=%0d hdg=%0d sat=%0b",
                 $signed(got.new_x), $signed(got.new_y), $signed(got.new_heading),
                 got.saturated);
      return;
    end
    e = expected_poses.pop_front();
    n_results++;
    if (got.new_x !== e.new_x || got.new_y !== e.new_y ||
        got.new_heading !== e.new_heading || got.saturated !== e.saturated) begin
      n_bad++;
      if (n_bad <= 10)
        $display("pose %0d: exp x=%0d y=%0d h=%0d s=%0b got x=%0d y=%0d h=%0d s=%0b",
                 n_results, $signed(e.new_x), $signed(e.new_y), $signed(e.new_heading),
                 e.saturated, $signed(got.new_x), $signed(got.new_y),
                 $signed(got.new_heading), got.saturated);
    end
  endfunction
endclass

module tb;
  import pou_pkg::*;

  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int ABITS       = ANGLE_BITS_DEF;
  localparam int N_RANDOM    = 1280;
  localparam int CALM_TAIL   = 300;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 80;
  localparam int WDOG_LIMIT  = 2000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pou_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pou_out_t out_data;

  int       tx_odds;
  int       rx_odds;
  bit       hold_req;
  int       idle_cycles;
  int       backpressure_cycles;
  int       n_directed;

  pose_scoreboard #(STAGES, ABITS) sb;

  pose_odometry_update_core #(
    .CORDIC_STAGES(STAGES),
    .ANGLE_BITS(ABITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic pou_in_t mk_pose(int px, int py, int th, int fw, int tn, int sl);
    pou_in_t r;
    r.pos_x = 32'(px);
    r.pos_y = 32'(py);
    r.heading = 16'(th);
    r.step_forward = 20'(fw);
    r.step_turn = 16'(tn);
    r.step_slip = 20'(sl);
    return r;
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 9))
      0, 1: return 32'h7FFFFFFF - $urandom_range(0, 1 << 20);
      2, 3: return 32'h80000000 + $urandom_range(0, 1 << 20);
      4: return $urandom_range(0, 8191) - 4096;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [19:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2, 3: return 20'($urandom_range(0, 2047) - 1024);
      default: return 20'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic pou_in_t rand_pose();
    pou_in_t r;
    r.pos_x = pick_pos();
    r.pos_y = pick_pos();
    r.heading = pick_angle();
    r.step_forward = pick_step();
    r.step_turn = pick_angle();
    r.step_slip = pick_step();
    return r;
  endfunction

  task automatic send_pose(pou_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pose(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_pose(out_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) backpressure_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                 idle_cycles, sb.expected_poses.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  initial begin
    sb = new();
    tx_odds = 0;
    rx_odds = 0;
    hold_req = 1'b0;
    idle_cycles = 0;
    backpressure_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pose(mk_pose(0, 0, 0, 0, 0, 0));
    send_pose(mk_pose(0, 0, 0, 524287, 0, 0));
    send_pose(mk_pose(0, 0, 0, -524288, 0, -524288));
    send_pose(mk_pose(0, 0, 16384, 524287, 0, 524287));
    send_pose(mk_pose(0, 0, -16384, -524288, 0, 524287));
    send_pose(mk_pose(0, 0, 16385, 524287, 0, -1));
    send_pose(mk_pose(0, 0, -16385, 524287, 0, 1));
    // mid angle lands on a half turn
    send_pose(mk_pose(0, 0, -32768, 524287, 0, 0));
    send_pose(mk_pose(0, 0, 16384, 524287, 32767, -524288));
    // heading wrap
    send_pose(mk_pose(0, 0, 32767, 1000, 1, -1000));
    send_pose(mk_pose(0, 0, -32768, 0, -1, 0));
    send_pose(mk_pose(0, 0, -32768, 300, -32768, 300));
    send_pose(mk_pose(0, 0, 32767, 4096, 32767, 4096));
    // clamping
    send_pose(mk_pose(32'h7FFFFFFF, 0, 0, 524287, 0, 0));
    send_pose(mk_pose(32'h80000000, 0, 0, -524288, 0, 0));
    send_pose(mk_pose(0, 32'h7FFFFFFF, 0, 0, 0, 524287));
    send_pose(mk_pose(0, 32'h80000000, 0, 0, 0, -524288));
    send_pose(mk_pose(32'h7FFFFFFF, 32'h80000000, -32768, -524288, 0, 524287));
    send_pose(mk_pose(32'h7FFFFFFF, 32'h7FFFFFFF, -32768, -524288, -32768, -524288));
    send_pose(mk_pose(32'h7FFFFF00, 0, 0, 1, 0, 0));
    send_pose(mk_pose(-1, -1, 8192, 1, -16384, -1));
    send_pose(mk_pose(12345678, -87654321, -12000, -200000, 30000, 150000));
    n_directed = sb.n_poses;

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        if (i >= N_RANDOM - CALM_TAIL) begin
          tx_odds = 0;
          rx_odds = 0;
        end else if (i == HOLD_AT) begin
          tx_odds = 0;
          rx_odds = 0;
          hold_req = 1'b1;
        end else begin
          tx_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8);
          rx_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8);
        end
      end
      if (tx_odds != 0 && $urandom_range(1, tx_odds) == 1) idle_for($urandom_range(1, 13));
      send_pose(rand_pose());
    end
    in_valid <= 1'b0;

    while (sb.expected_poses.size() != 0) @(posedge clk);
    repeat (STAGES + 8) @(posedge clk);

    $display("Covered %0d poses (%0d directed), %0d of them clamped, %0d results checked.",
             sb.n_poses, n_directed, sb.n_clamped, sb.n_results);
    $display("Input was back-pressured for %0d cycles; %0d results were wrong or unexpected.",
             backpressure_cycles, sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### filelist.f
src/pou_pkg.sv
src/pou_prep.sv
src/pou_cordic.sv
src/pou_scale.sv
src/pose_odometry_update_core.sv
bench/tb.sv
